>>> hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and result codes shared by the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LENGTH   = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_stream;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic [1:0]  status;
        logic        eos;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets, gathers groups of four and
// pushes one output job per completed group or per stream end.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_t           s_data,
    input  queue_status_t queue_status,
    output logic          push,
    output job_t          push_job
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] store_reg, store_next;
    logic        third_pad_reg, third_pad_next;
    logic        bad_reg, bad_next;

    logic [5:0]  sextet;
    logic        char_ok;
    logic        is_pad;
    logic        accept;

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] r;
        r = {1'b0, 6'd0};
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else if (c == PAD_CHAR) begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

    assign {char_ok, sextet} = classify(s_data.in_char);
    assign is_pad  = (s_data.in_char == PAD_CHAR);
    assign s_ready = !queue_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next       = pos_reg;
        store_next     = store_reg;
        third_pad_next = third_pad_reg;
        bad_next       = bad_reg;
        push           = 1'b0;
        push_job       = '0;
        if (accept) begin
            if (pos_reg != 2'd3) begin
                store_next     = {store_reg[11:0], sextet};
                pos_next       = pos_reg + 2'd1;
                third_pad_next = third_pad_reg || (pos_reg == 2'd2 && is_pad);
                bad_next       = bad_reg || !char_ok;
                if (s_data.end_of_input) begin
                    push            = 1'b1;
                    push_job.triple = '0;
                    push_job.count  = COUNT_ONE;
                    push_job.status = STATUS_LENGTH;
                    push_job.eos    = 1'b1;
                    pos_next        = '0;
                    store_next      = '0;
                    third_pad_next  = 1'b0;
                    bad_next        = 1'b0;
                end
            end else begin
                push            = 1'b1;
                push_job.triple = {store_reg, sextet};
                push_job.count  = COUNT_THREE
                                  - 2'(s_data.end_of_input && is_pad)
                                  - 2'(s_data.end_of_input && third_pad_reg);
                push_job.status = (bad_reg || !char_ok) ? STATUS_BAD_CHAR : STATUS_OK;
                push_job.eos    = s_data.end_of_input;
                pos_next        = '0;
                store_next      = '0;
                third_pad_next  = 1'b0;
                bad_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            store_reg     <= '0;
            third_pad_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            store_reg     <= store_next;
            third_pad_reg <= third_pad_next;
            bad_reg       <= bad_next;
        end
    end

endmodule

>>> hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue that parts the front and back so each can stall alone.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
    parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t queue_status
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    job_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign queue_status.full  = (cnt_reg == FullCnt);
    assign queue_status.empty = (cnt_reg == '0);
    assign do_push  = push && !queue_status.full;
    assign do_pop   = pop && !queue_status.empty;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and emits their bytes, one per transaction,
// through a registered output stage.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  job_t          head_job,
    input  queue_status_t queue_status,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output out_t          m_data
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    out_t       data_reg, data_next;
    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = !queue_status.empty && (!valid_reg || m_ready);
    assign last = (idx_reg == head_job.count - 2'd1);
    assign pop  = load && last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head_job.triple[23:16];
            2'd1:    sel_byte = head_job.triple[15:8];
            default: sel_byte = head_job.triple[7:0];
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next              = 1'b1;
            data_next.out_byte      = sel_byte;
            data_next.last_of_run   = last;
            data_next.end_of_stream = last && head_job.eos;
            data_next.status        = head_job.status;
            idx_next                = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> hdl/base64_stream_decoder.sv
// The first byte of a group is written into the job queue when its fourth
// character is taken, then loaded into the output register; the others follow.
// Throughput: one character per cycle while the job queue is not full; one byte
// per cycle leaves the output register while m_ready; the queue absorbs the gap.
// Reset: synchronous active-low aresetn clears the group, queue and output valid.
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 character stream to byte stream decoder, standard alphabet.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; #(
    parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    queue_status_t queue_status;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head_job;

    b64d_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .queue_status (queue_status),
        .push         (push),
        .push_job     (push_job)
    );

    b64d_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .push_job     (push_job),
        .pop          (pop),
        .head_job     (head_job),
        .queue_status (queue_status)
    );

    b64d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_job     (head_job),
        .queue_status (queue_status),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

>>> hdl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before transaction");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    a_eos_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_of_stream |-> m_data.last_of_run)
        else $error("end of stream without last of run");

    a_length_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_LENGTH |->
            m_data.out_byte == 8'd0 && m_data.end_of_stream && m_data.last_of_run)
        else $error("malformed length error result");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_OK || m_data.status == STATUS_LENGTH
                    || m_data.status == STATUS_BAD_CHAR)
        else $error("undefined status code");

endmodule

bind base64_stream_decoder b64d_checker u_checker (.*);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for base64_stream_decoder, the Base64 character to byte decoder.
// It starts with a short table of characters that covers length errors, all
// pad positions, invalid characters and the extreme codes. Random streams
// follow, mostly well formed, with some broken lengths and noise. The sender
// and receiver idle at random in several phases. A behavioral decoder tracks
// every accepted transaction and predicts the bytes it should produce. Each
// output transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_CHARS = 48;
    localparam int LONG_HOLD = 60;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    out_t awaited_bytes[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    int   chars_sent = 0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    bit   hold_request = 1'b0;

    logic [1:0]  grp_pos = '0;
    logic [17:0] held_sextets = '0;
    logic        third_pad = 1'b0;
    logic        bad_seen = 1'b0;

    row_t directed_rows[23] = '{
        '{'{"A", 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, STATUS_LENGTH}},
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b1, STATUS_OK}},
        '{'{"A", 1'b0}, 1'b0, '0},
        '{'{"A", 1'b0}, 1'b0, '0},
        '{'{"A", 1'b0}, 1'b0, '0},
        '{'{"A", 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, STATUS_OK}},
        '{'{"+", 1'b0}, 1'b0, '0},
        '{'{"9", 1'b0}, 1'b0, '0},
        '{'{"z", 1'b0}, 1'b0, '0},
        '{'{"=", 1'b1}, 1'b0, '0},
        '{'{"Z", 1'b0}, 1'b0, '0},
        '{'{"g", 1'b0}, 1'b0, '0},
        '{'{"=", 1'b0}, 1'b0, '0},
        '{'{"=", 1'b1}, 1'b1, '{8'h66, 1'b1, 1'b1, STATUS_OK}},
        '{'{"a", 1'b0}, 1'b0, '0},
        '{'{"*", 1'b0}, 1'b0, '0},
        '{'{"b", 1'b0}, 1'b0, '0},
        '{'{"=", 1'b0}, 1'b1, '{8'hC0, 1'b1, 1'b0, STATUS_BAD_CHAR}},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, STATUS_LENGTH}}
    };

    base64_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [5:0] to_sextet(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
        if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
        if (c == 8'h2B) return 6'd62;
        if (c == 8'h2F) return 6'd63;
        ok = (c == PAD_CHAR);
        return 6'd0;
    endfunction

    function automatic logic [7:0] to_char(input logic [5:0] s);
        if (s < 6'd26) return 8'h41 + 8'(s);
        if (s < 6'd52) return 8'h61 + 8'(s) - 8'd26;
        if (s < 6'd62) return 8'h30 + 8'(s) - 8'd52;
        return (s == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic void clear_group();
        grp_pos = '0;
        held_sextets = '0;
        third_pad = 1'b0;
        bad_seen = 1'b0;
    endfunction

    task automatic decode_char(input in_t it);
        logic [5:0]  sx;
        logic        ok;
        logic        pad;
        logic [23:0] triple;
        logic [1:0]  st;
        int          n;
        out_t        r;
        sx = to_sextet(it.in_char, ok);
        pad = (it.in_char == PAD_CHAR);
        if (!ok) bad_seen = 1'b1;
        if (grp_pos != 2'd3) begin
            if (grp_pos == 2'd2 && pad) third_pad = 1'b1;
            held_sextets = {held_sextets[11:0], sx};
            grp_pos = grp_pos + 2'd1;
            if (it.end_of_input) begin
                clear_group();
                awaited_bytes.push_back('{8'h00, 1'b1, 1'b1, STATUS_LENGTH});
            end
        end else begin
            triple = {held_sextets, sx};
            st = bad_seen ? STATUS_BAD_CHAR : STATUS_OK;
            n = 3;
            if (it.end_of_input) begin
                if (pad) n--;
                if (third_pad) n--;
            end
            for (int k = 0; k < n; k++) begin
                r.out_byte = triple[23 - 8 * k -: 8];
                r.last_of_run = (k == n - 1);
                r.end_of_stream = it.end_of_input && (k == n - 1);
                r.status = st;
                awaited_bytes.push_back(r);
            end
            clear_group();
        end
    endtask

    task automatic send_item(input in_t it);
        while ($urandom_range(1, 100) <= send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_char(it);
        chars_sent++;
    endtask

    task automatic send_stream();
        int         kind;
        int         groups;
        int         pads;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            groups = $urandom_range(1, 4);
            pads = $urandom_range(0, 3);
            len = 4 * groups;
            for (int i = 0; i < len; i++) begin
                c = to_char(6'($urandom_range(0, 63)));
                if (i == len - 1 && (pads == 1 || pads == 2)) c = PAD_CHAR;
                if (i == len - 2 && pads >= 2) c = PAD_CHAR;
                if ($urandom_range(0, 15) == 0)
                    c = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
                send_item('{c, i == len - 1});
            end
        end else if (kind < 9) begin
            len = $urandom_range(1, 11);
            for (int i = 0; i < len; i++)
                send_item('{to_char(6'($urandom_range(0, 63))), i == len - 1});
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_item('{8'($urandom_range(0, 255)),
                            i == len - 1 || $urandom_range(0, 5) == 0});
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (awaited_bytes.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        out_t exp_byte;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_bytes.size() == 0) begin
                $error("unexpected transaction: out_byte %0h", m_data.out_byte);
                fail_count++;
            end else begin
                exp_byte = awaited_bytes.pop_front();
                check_field("out_byte", exp_byte.out_byte, m_data.out_byte);
                check_field("last_of_run", 8'(exp_byte.last_of_run), 8'(m_data.last_of_run));
                check_field("end_of_stream", 8'(exp_byte.end_of_stream),
                            8'(m_data.end_of_stream));
                check_field("status", 8'(exp_byte.status), 8'(m_data.status));
            end
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    initial begin
        int first;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].typed)
                awaited_bytes[awaited_bytes.size() - 1] = directed_rows[i].want;
        end
        for (int ph = 0; ph < 4; ph++) begin
            s_valid <= 1'b0;
            wait_drained();
            case (ph)
                0: begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                    hold_request = 1'b1;
                end
                1: begin
                    send_gap_pct = 56;
                    stall_pct = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct = 56;
                end
                default: begin
                    send_gap_pct = 32;
                    stall_pct = 32;
                end
            endcase
            first = chars_sent;
            while (chars_sent - first < PHASE_CHARS) send_stream();
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (awaited_bytes.size() != 0) begin
            $error("%0d expected transactions never arrived", awaited_bytes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> base64_stream_decoder.f
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder.sv
hdl/b64d_checker.sv
test/tb.sv
